// ===== rtl/fsts_pkg.sv =====
// package for the fixed step tick scheduler
// holds widths, register indexes, request codes and the sequencer state type
// no dependencies
`default_nettype none
package fsts_pkg;

  localparam int TIME_WIDTH_DEF  = 48;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int PERIOD_W = 32;
  localparam int SEND_W   = 16;
  localparam int MCU_W    = 8;
  localparam int CFG_W    = 32;
  localparam int CFG_AW   = 2;

  localparam logic [PERIOD_W-1:0] TICK_LEN_RST  = PERIOD_W'(1000000);
  localparam logic [SEND_W-1:0]   FLAG_DIV_RST  = SEND_W'(1);
  localparam logic [MCU_W-1:0]    LAG_LIMIT_RST = MCU_W'(5);

  localparam logic [CFG_AW-1:0] CFG_TICK_LEN  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_FLAG_DIV  = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_LAG_LIMIT = CFG_AW'(2);

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_NEXT   = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CHECK,
    ST_LOST,
    ST_ADV,
    ST_SEND,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/fsts_div.sv =====
// restoring divider, one quotient bit per cycle
// used for the catch-up period count and the send flag modulo; needs fsts_pkg
`default_nettype none
module fsts_div
  import fsts_pkg::*;
#(
  parameter int DIVIDEND_W = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [PERIOD_W-1:0]   divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [PERIOD_W-1:0]        remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [PERIOD_W-1:0]   rem_r, rem_nxt;
  logic [PERIOD_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [PERIOD_W:0]     shifted;
  logic [PERIOD_W+1:0]   diff;
  logic                  borrow;

  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    borrow  = diff[PERIOD_W+1];

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ~borrow};
      rem_nxt = borrow ? shifted[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ===== rtl/fixed_step_tick_scheduler.sv =====
// fixed step tick scheduler with catch-up limit
// top level: sequencer, scheduler state, config registers, output register
// depends on fsts_pkg and fsts_div
//
// input stream: in_tuser carries the request kind (start, next, cancel, no-op),
// in_tdata the current time. one transaction in gives one transaction out.
// output stream: out_tuser is the ended flag; out_tdata carries tick index,
// send flag, waited flag, release time and skipped total.
// config port: cfg_we writes cfg_wdata into the register at cfg_addr
// (0 period, 1 send interval, 2 catch-up limit); write only when idle.
// start, cancel, no-op and next-after-cancel go straight to the output stage;
// a next request compares the time with the deadline and, if released at
// once, checks whether the lag exceeds the catch-up limit times the period,
// in which case the lost periods are skipped; it then advances the tick and
// gets the send flag. the shared one-bit-per-cycle divider is used once for
// the send modulo and, if periods are lost, once more for the catch-up count.
// in_tready is high only while the sequencer is idle, so an item is taken
// only once the last has left the sequencer; a finished result waits in the
// output register while out_tready is low, the next item is accepted meanwhile
// and its result is held in the sequencer until the register frees up.
// reset (rst_n low, synchronous) restores the register defaults, clears the
// deadline, counters and cancelled flag, and empties the output register.
`default_nettype none
module fixed_step_tick_scheduler
  import fsts_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int IN_W  = ((TIME_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COUNT_WIDTH + TIME_WIDTH + 2 + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // now_time
  input  wire logic [1:0]        in_tuser,   // req_type
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // tick_index, send_flag, waited,
                                             // release_time, skipped_total
  output logic [0:0]             out_tuser,  // ended
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int TW     = TIME_WIDTH;
  localparam int CW     = COUNT_WIDTH;
  localparam int DW     = (TW > CW) ? TW : CW;
  localparam int PROD_W = MCU_W + PERIOD_W;
  localparam int CMP_W  = (TW > PROD_W) ? TW : PROD_W;

  state_t state_r, state_nxt;

  logic [PERIOD_W-1:0] tick_len_r;
  logic [SEND_W-1:0]   flag_div_r;
  logic [MCU_W-1:0]    lag_limit_r;

  logic [TW-1:0]     deadline_r, deadline_nxt;
  logic [CW-1:0]     tick_r, tick_nxt;
  logic [CW-1:0]     skip_r, skip_nxt;
  logic              cancelled_r, cancelled_nxt;

  logic [TW-1:0]     now_r, now_nxt;
  logic [TW-1:0]     behind_r, behind_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              send_r, send_nxt;
  logic              waited_r, waited_nxt;
  logic [TW-1:0]     rel_r, rel_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              out_ended_r, out_ended_nxt;

  logic [PERIOD_W-1:0] period_c;
  logic [SEND_W-1:0]   every_c;
  logic                in_acc;
  req_t                req_c;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic                div_done;
  logic [DW-1:0]       div_quo;
  logic [PERIOD_W-1:0] div_rem;

  fsts_div #(
    .DIVIDEND_W (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign period_c  = (tick_len_r == '0) ? PERIOD_W'(1) : tick_len_r;
  assign every_c   = (flag_div_r == '0) ? SEND_W'(1) : flag_div_r;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign req_c     = req_t'(in_tuser);

  always_comb begin
    state_nxt     = state_r;
    deadline_nxt  = deadline_r;
    tick_nxt      = tick_r;
    skip_nxt      = skip_r;
    cancelled_nxt = cancelled_r;
    now_nxt       = now_r;
    behind_nxt    = behind_r;
    prod_nxt      = prod_r;
    send_nxt      = send_r;
    waited_nxt    = waited_r;
    rel_nxt       = rel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_ended_nxt = out_ended_r;
    div_start     = 1'b0;
    div_dividend  = DW'(behind_r);
    div_divisor   = period_c;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt    = in_tdata[TW-1:0];
          send_nxt   = 1'b0;
          waited_nxt = 1'b0;
          rel_nxt    = '0;
          state_nxt  = ST_DONE;
          unique case (req_c)
            REQ_START: begin
              deadline_nxt  = in_tdata[TW-1:0] + TW'(period_c);
              tick_nxt      = '0;
              skip_nxt      = '0;
              cancelled_nxt = 1'b0;
            end
            REQ_CANCEL: begin
              cancelled_nxt = 1'b1;
            end
            REQ_NEXT: begin
              if (!cancelled_r) begin
                state_nxt = ST_CMP;
              end
            end
            REQ_NOP: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        if (deadline_r > now_r) begin
          waited_nxt = 1'b1;
          rel_nxt    = deadline_r;
          state_nxt  = ST_ADV;
        end else begin
          rel_nxt    = now_r;
          behind_nxt = now_r - deadline_r;
          prod_nxt   = PROD_W'(lag_limit_r) * PROD_W'(period_c);
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (CMP_W'(behind_r) > CMP_W'(prod_r)) begin
          div_start = 1'b1;
          state_nxt = ST_LOST;
        end else begin
          state_nxt = ST_ADV;
        end
      end
      ST_LOST: begin
        if (div_done) begin
          // deadline + lost * period equals now minus the remainder
          skip_nxt     = skip_r + div_quo[CW-1:0];
          deadline_nxt = now_r - TW'(div_rem);
          state_nxt    = ST_ADV;
        end
      end
      ST_ADV: begin
        deadline_nxt = deadline_r + TW'(period_c);
        tick_nxt     = tick_r + CW'(1);
        div_start    = 1'b1;
        div_dividend = DW'(tick_nxt);
        div_divisor  = PERIOD_W'(every_c);
        state_nxt    = ST_SEND;
      end
      ST_SEND: begin
        if (div_done) begin
          send_nxt  = (div_rem == '0);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ended_nxt = cancelled_r;
          out_data_nxt  = OUT_W'({skip_r, rel_r, waited_r, send_r, tick_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_len_r  <= TICK_LEN_RST;
      flag_div_r  <= FLAG_DIV_RST;
      lag_limit_r <= LAG_LIMIT_RST;
      deadline_r  <= '0;
      tick_r      <= '0;
      skip_r      <= '0;
      cancelled_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      deadline_r  <= deadline_nxt;
      tick_r      <= tick_nxt;
      skip_r      <= skip_nxt;
      cancelled_r <= cancelled_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TICK_LEN:  tick_len_r  <= cfg_wdata[PERIOD_W-1:0];
          CFG_FLAG_DIV:  flag_div_r  <= cfg_wdata[SEND_W-1:0];
          CFG_LAG_LIMIT: lag_limit_r <= cfg_wdata[MCU_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    behind_r    <= behind_nxt;
    prod_r      <= prod_nxt;
    send_r      <= send_nxt;
    waited_r    <= waited_nxt;
    rel_r       <= rel_nxt;
    out_data_r  <= out_data_nxt;
    out_ended_r <= out_ended_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ended_r;

endmodule
`default_nettype wire
